FILE: design/vdi_pkg.sv
package vdi_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned COMP_W          = 32;
    localparam int unsigned NUM_COMP        = 8;
    localparam int unsigned TOL_W           = 17;
    localparam int unsigned IDX_OUT_W       = 10;
    localparam logic [TOL_W-1:0] TOL_RESET  = 17'd656;

    // APB data width and register map
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;
    localparam logic        REG_TOL = 1'b0;   // word index, paddr[2]

    typedef struct packed {
        logic signed [COMP_W-1:0] pos_x;
        logic signed [COMP_W-1:0] pos_y;
        logic signed [COMP_W-1:0] pos_z;
        logic signed [COMP_W-1:0] tex_u;
        logic signed [COMP_W-1:0] tex_v;
        logic signed [COMP_W-1:0] norm_x;
        logic signed [COMP_W-1:0] norm_y;
        logic signed [COMP_W-1:0] norm_z;
    } vdi_in_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] vertex_index;
        logic                 is_new;
        logic                 overflow;
    } vdi_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } vdi_state_t;

endpackage

FILE: design/vdi_ram.sv
module vdi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/vdi_cmp.sv
module vdi_cmp
    import vdi_pkg::*;
(
    input  vdi_in_t          a,
    input  vdi_in_t          b,
    input  logic [TOL_W-1:0] tol,
    output logic             hit
);

    logic [NUM_COMP*COMP_W-1:0] a_flat;
    logic [NUM_COMP*COMP_W-1:0] b_flat;
    logic [NUM_COMP-1:0]        close;
    logic signed [COMP_W:0]     tol_pos;
    logic signed [COMP_W:0]     tol_neg;

    assign a_flat  = a;
    assign b_flat  = b;
    assign tol_pos = $signed({{(COMP_W+1-TOL_W){1'b0}}, tol});
    assign tol_neg = -tol_pos;

    // exact signed difference on 33 bits; close means -tol < d < tol
    always_comb
    begin
        logic signed [COMP_W:0] ax;
        logic signed [COMP_W:0] bx;
        logic signed [COMP_W:0] d;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            ax = $signed({a_flat[c*COMP_W+COMP_W-1], a_flat[c*COMP_W +: COMP_W]});
            bx = $signed({b_flat[c*COMP_W+COMP_W-1], b_flat[c*COMP_W +: COMP_W]});
            d  = ax - bx;
            close[c] = (d < tol_pos) && (d > tol_neg);
        end
    end

    assign hit = &close;

endmodule

FILE: design/vertex_dedup_indexer_unit.sv
// Vertex dedup indexer: linear scan of a unique-vertex table, one entry per cycle.
// Outcomes: an empty table appends at entry 0 straight from idle, with no scan; otherwise
// the scan ends on a hit at entry k, or at the last entry on a miss (append or overflow).
// A new request is accepted only while busy is low; the single table RAM read port serves one scan at a time.
// Reset (rst_n, async low) empties the table and loads the default tolerance;
// done is a one-cycle strobe the receiver cannot stall; busy drops as done rises.
module vertex_dedup_indexer_unit
    import vdi_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              start,
    output logic              busy,
    input  vdi_in_t           vtx,
    // result channel
    output logic              done,
    output vdi_out_t          result,
    // APB config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned VTX_W  = $bits(vdi_in_t);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Config: match tolerance
    // ------------------------------------------------------------------
    logic [TOL_W-1:0] tol_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_wr)
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TOL)
        begin
            prdata = {{(APB_DW-TOL_W){1'b0}}, tol_reg};
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    vdi_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;       // stored entries
    logic [CNT_W-1:0] idx_reg, idx_next;       // entry whose data is on rdata
    logic             done_reg, done_next;
    vdi_out_t         result_reg, result_next;
    vdi_in_t          vtx_reg, vtx_next;

    // RAM side
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    vdi_in_t           ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VTX_W-1:0]  ram_rdata;

    logic             accept;
    logic             hit;
    logic             last;
    logic             full;
    logic [CNT_W-1:0] idx_inc;

    assign busy    = (state_reg == ST_SCAN);
    assign accept  = start && !busy;
    assign idx_inc = CNT_W'(idx_reg + 1'b1);
    assign last    = (idx_inc == cnt_reg);
    assign full    = (cnt_reg == FULL_CNT);

    vdi_ram #(
        .WIDTH (VTX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // all eight components of the held request vs. the entry just read
    vdi_cmp u_cmp (
        .a   (vtx_reg),
        .b   (vdi_in_t'(ram_rdata)),
        .tol (tol_reg),
        .hit (hit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cnt_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath / outputs
    always_comb
    begin
        logic [IDX_OUT_W+CNT_W-1:0] idx_ext;
        idx_ext     = '0;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        vtx_next    = vtx_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[ADDR_W-1:0];
        ram_wdata   = vtx_reg;
        ram_raddr   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = '0;
                if (accept)
                begin
                    vtx_next = vtx;
                    idx_next = '0;
                    if (cnt_reg == '0)
                    begin
                        // empty table: append at entry 0 right away
                        ram_we      = 1'b1;
                        ram_wdata   = vtx;
                        cnt_next    = CNT_W'(1);
                        done_next   = 1'b1;
                        result_next = '{vertex_index: '0, is_new: 1'b1, overflow: 1'b0};
                    end
                end
            end
            ST_SCAN:
            begin
                ram_raddr = idx_inc[ADDR_W-1:0];
                idx_next  = idx_inc;
                if (hit)
                begin
                    idx_ext     = {{IDX_OUT_W{1'b0}}, idx_reg};
                    done_next   = 1'b1;
                    result_next = '{vertex_index: idx_ext[IDX_OUT_W-1:0],
                                    is_new: 1'b0, overflow: 1'b0};
                end
                else if (last)
                begin
                    done_next = 1'b1;
                    if (full)
                    begin
                        result_next = '{vertex_index: '0, is_new: 1'b0, overflow: 1'b1};
                    end
                    else
                    begin
                        idx_ext     = {{IDX_OUT_W{1'b0}}, cnt_reg};
                        ram_we      = 1'b1;
                        cnt_next    = CNT_W'(cnt_reg + 1'b1);
                        result_next = '{vertex_index: idx_ext[IDX_OUT_W-1:0],
                                        is_new: 1'b1, overflow: 1'b0};
                    end
                end
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        vtx_reg    <= vtx_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count above table depth");

    a_new_bumps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_new) |-> (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)))
        else $error("new entry without count increment");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (full && !result.is_new))
        else $error("overflow reported on non-full table");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result strobe without a request");

endmodule
